// ----- src/gir_pkg.sv -----
// Gamepad input remapper: shared types, codes and constants.
// No dependencies; imported by gamepad_input_remapper.
package gir_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset sweep of slot memories
    ST_IDLE,    // waiting for an input transfer
    ST_LOOKUP,  // read map and level of the slot being changed
    ST_CHECK,   // compare level, write it, pick up target
    ST_WALK,    // stream every walked slot through the adder
    ST_DRAIN,   // last read in flight
    ST_FINISH,  // clamp, compare, queue event
    ST_DONE     // flush queued event with tlast
  } gir_state_t;

  // Operation codes (s_tuser)
  localparam logic [1:0] OP_AXIS   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_MAP    = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_NUM_AXES    = 1'b0;
  localparam logic REG_NUM_BUTTONS = 1'b1;

  // Map byte layout
  localparam logic [7:0] MAP_NONE = 8'hFF;
  localparam int MAP_BUTTON_BIT   = 7;
  localparam int MAP_NEGATE_BIT   = 6;

  // Width of 2*num_axes + num_buttons
  localparam int SPAN_W = 10;

  localparam logic signed [15:0] RAW_MIN   = -16'sd32768;
  localparam logic signed [15:0] VALUE_MIN = -16'sd32767;
  localparam logic signed [15:0] VALUE_MAX = 16'sd32767;
  localparam logic signed [17:0] PAIR_BIAS = 18'sd32768;

  // Slot map byte selects the given virtual output
  function automatic logic slot_match(input logic [7:0] m, input logic btn,
                                      input logic [5:0] t);
    return (m != MAP_NONE) && (m[MAP_BUTTON_BIT] == btn) && (m[5:0] == t);
  endfunction

endpackage

// ----- src/gamepad_input_remapper.sv -----
// Gamepad input remapper top level: slot memories, shared re-sum adder, sequencer.
// Depends on gir_pkg.
// Update: each changed half is looked up, checked, then walked slot by slot through the adder;
//   W = walked slots rounded up to even (one slot read per cycle from the slot memories).
// Flow: one item at a time, s_tready only in idle; map writes are done in idle on acceptance.
// Reset: synchronous; afterwards a clearing pass over NUM_SLOTS (rounded up to even) slots
//   fills the map with 0xFF and levels with 0 before the first item is taken.
module gamepad_input_remapper #(
  parameter int NUM_SLOTS       = 256,
  parameter int NUM_AXIS_OUTS   = 6,
  parameter int NUM_BUTTON_OUTS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // index[7:0], raw_value[23:8], map_entry[31:24]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // target_index[3:0], target_value[19:4], zero pad
  output logic        m_tuser,   // target_is_button
  output logic        m_tlast    // last
);
  import gir_pkg::*;

  // Memory rounded up to whole axis pairs so the walk always reads in pairs
  localparam int MEM_DEPTH = NUM_SLOTS + (NUM_SLOTS % 2);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
  localparam int ACC_W     = 17 + ADDR_W;
  localparam int AX_W      = (NUM_AXIS_OUTS > 1) ? $clog2(NUM_AXIS_OUTS) : 1;
  localparam int BT_W      = (NUM_BUTTON_OUTS > 1) ? $clog2(NUM_BUTTON_OUTS) : 1;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-32767);
  localparam logic [SPAN_W-1:0] SLOTS_LIM = SPAN_W'(NUM_SLOTS);

  gir_state_t state, state_next;

  // configuration registers
  logic [7:0] num_axes;
  logic [7:0] num_buttons;

  // slot memories
  logic [7:0]  slot_map   [MEM_DEPTH];
  logic [14:0] slot_level [MEM_DEPTH];
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_we_map, mem_we_lvl;
  logic [7:0]        mem_wmap;
  logic [14:0]       mem_wlvl;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        map_rd;
  logic [14:0]       lvl_rd;

  // virtual output values
  logic signed [15:0] axis_out   [NUM_AXIS_OUTS];
  logic [14:0]        button_out [NUM_BUTTON_OUTS];

  // sequencer registers
  logic [ADDR_W-1:0] clr_idx;
  logic [ADDR_W-1:0] cur_slot;
  logic [14:0]       new_level, second_level;
  logic              second_pend;
  logic              tgt_btn;
  logic [5:0]        tgt_t;
  logic [CNT_W-1:0]  walk_idx;
  logic              rd_vld;
  logic [ADDR_W-1:0] rd_pos;
  logic [7:0]        even_map;
  logic [14:0]       even_lvl;
  logic signed [ACC_W-1:0] acc;

  // held event, released once we know whether it is the last one
  logic        pend_valid, pend_btn;
  logic [3:0]  pend_idx;
  logic [15:0] pend_value;

  // output register
  logic        out_btn, out_last;
  logic [3:0]  out_idx;
  logic [15:0] out_value;

  // ---------------- input decode ----------------
  logic [1:0]         in_op;
  logic [7:0]         in_index;
  logic signed [15:0] in_raw, raw_fix;
  logic [7:0]         in_map;
  logic [14:0]        neg_lvl, pos_lvl;
  logic [SPAN_W-1:0]  btn_slot_full, span_full, pair_lim;
  logic               axis_ok, btn_ok, map_ok;
  logic [CNT_W-1:0]   walk_len, walk_end;

  always_comb begin
    in_op    = s_tuser;
    in_index = s_tdata[7:0];
    in_raw   = signed'(s_tdata[23:8]);
    in_map   = s_tdata[31:24];
    raw_fix  = (in_raw == RAW_MIN) ? VALUE_MIN : in_raw;
    neg_lvl  = (raw_fix < 16'sd0) ? 15'(-raw_fix) : 15'd0;
    pos_lvl  = (raw_fix > 16'sd0) ? raw_fix[14:0] : 15'd0;

    pair_lim      = {1'b0, num_axes, 1'b0};
    btn_slot_full = pair_lim + {2'b00, in_index};
    span_full     = pair_lim + {2'b00, num_buttons};
    axis_ok       = {1'b0, in_index, 1'b1} < SLOTS_LIM;  // both halves must fit
    btn_ok        = btn_slot_full < SLOTS_LIM;
    map_ok        = {2'b00, in_index} < SLOTS_LIM;
    walk_len      = (span_full > SLOTS_LIM) ? CNT_W'(NUM_SLOTS) : span_full[CNT_W-1:0];
    walk_end      = walk_len + CNT_W'(walk_len[0]);
  end

  // ---------------- shared re-sum adder ----------------
  // Slots are consumed in pairs: the even slot is held until its odd partner
  // arrives so an unsigned axis pair can be recognised and counted once.
  logic [ADDR_W-1:0]  pos_even, pos_odd;
  logic               in_e, in_o, match_e, match_o, is_pair;
  logic signed [17:0] cont_e, cont_o, pair_d, pair_val, step_add;

  always_comb begin
    pos_even = rd_pos & ~ADDR_W'(1);
    pos_odd  = rd_pos | ADDR_W'(1);
    in_e     = CNT_W'(pos_even) < walk_len;
    in_o     = CNT_W'(pos_odd) < walk_len;
    match_e  = slot_match(even_map, tgt_btn, tgt_t) && in_e;
    match_o  = slot_match(map_rd, tgt_btn, tgt_t) && in_o;
    is_pair  = !tgt_btn && (SPAN_W'(pos_odd) < pair_lim) && (SPAN_W'(pos_odd) < SLOTS_LIM)
               && (even_map == map_rd) && match_o;

    cont_e = 18'sd0;
    if (match_e) begin
      cont_e = even_map[MAP_NEGATE_BIT] ? -signed'({3'b000, even_lvl})
                                        : signed'({3'b000, even_lvl});
    end
    cont_o = 18'sd0;
    if (match_o) begin
      cont_o = map_rd[MAP_NEGATE_BIT] ? -signed'({3'b000, lvl_rd})
                                      : signed'({3'b000, lvl_rd});
    end

    pair_d   = map_rd[MAP_NEGATE_BIT] ? signed'({3'b000, even_lvl}) - signed'({3'b000, lvl_rd})
                                      : signed'({3'b000, lvl_rd}) - signed'({3'b000, even_lvl});
    pair_val = (pair_d + PAIR_BIAS) >>> 1;
    step_add = is_pair ? pair_val : (cont_e + cont_o);
  end

  // ---------------- clamp and compare ----------------
  logic              tgt_ok;
  logic [15:0]       clamp_val, cur_out;
  logic              value_changed;

  always_comb begin
    tgt_ok = (map_rd != MAP_NONE) &&
             (map_rd[MAP_BUTTON_BIT] ? ({1'b0, map_rd[5:0]} < 7'(NUM_BUTTON_OUTS))
                                     : ({1'b0, map_rd[5:0]} < 7'(NUM_AXIS_OUTS)));
    if (acc > ACC_HI) begin
      clamp_val = VALUE_MAX;
    end else if (tgt_btn && acc < ACC_W'(0)) begin
      clamp_val = 16'd0;
    end else if (acc < ACC_LO) begin
      clamp_val = VALUE_MIN;
    end else begin
      clamp_val = acc[15:0];
    end
    cur_out = tgt_btn ? {1'b0, button_out[tgt_t[BT_W-1:0]]} : axis_out[tgt_t[AX_W-1:0]];
    value_changed = clamp_val != cur_out;
  end

  // ---------------- sequencer ----------------
  logic accept, out_free, level_same, go_next, out_load, out_load_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = (state == ST_IDLE);
    accept        = s_tvalid && s_tready;
    out_free      = !m_tvalid || m_tready;
    level_same    = (lvl_rd == new_level);
    go_next       = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    mem_waddr     = cur_slot;
    mem_we_map    = 1'b0;
    mem_we_lvl    = 1'b0;
    mem_wmap      = in_map;
    mem_wlvl      = new_level;
    rd_addr       = (state == ST_WALK) ? walk_idx[ADDR_W-1:0] : cur_slot;

    case (state)
      ST_CLEAR: begin
        mem_waddr  = clr_idx;
        mem_we_map = 1'b1;
        mem_we_lvl = 1'b1;
        mem_wmap   = MAP_NONE;
        mem_wlvl   = 15'd0;
        if (clr_idx == ADDR_W'(MEM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_AXIS:   if (axis_ok) state_next = ST_LOOKUP;
            OP_BUTTON: if (btn_ok) state_next = ST_LOOKUP;
            OP_MAP: begin
              mem_waddr  = ADDR_W'(in_index);
              mem_we_map = map_ok;
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: state_next = ST_CHECK;
      ST_CHECK: begin
        mem_we_lvl = !level_same;
        if (level_same || !tgt_ok) begin
          go_next    = 1'b1;
          state_next = second_pend ? ST_LOOKUP : ST_DONE;
        end else if (walk_end == CNT_W'(0)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_idx + CNT_W'(1) == walk_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          go_next    = 1'b1;
          out_load   = value_changed && pend_valid;
          state_next = second_pend ? ST_LOOKUP : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we_map) slot_map[mem_waddr] <= mem_wmap;
    if (mem_we_lvl) slot_level[mem_waddr] <= mem_wlvl;
    map_rd <= slot_map[rd_addr];
    lvl_rd <= slot_level[rd_addr];
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_NUM_BUTTONS) ? num_buttons : num_axes};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_axes    <= 8'd0;
      num_buttons <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_NUM_AXES) begin
        num_axes <= pwdata[7:0];
      end else begin
        num_buttons <= pwdata[7:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      second_pend <= 1'b0;
      pend_valid  <= 1'b0;
      rd_vld      <= 1'b0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < NUM_AXIS_OUTS; i++) axis_out[i] <= 16'sd0;
      for (int i = 0; i < NUM_BUTTON_OUTS; i++) button_out[i] <= 15'd0;
    end else begin
      rd_vld <= (state == ST_WALK);
      if (state == ST_CLEAR) clr_idx <= clr_idx + ADDR_W'(1);

      if (accept) begin
        second_pend <= (in_op == OP_AXIS);
      end else if (go_next) begin
        second_pend <= 1'b0;
      end

      if (state == ST_FINISH && out_free && value_changed) begin
        pend_valid <= 1'b1;
        if (tgt_btn) begin
          button_out[tgt_t[BT_W-1:0]] <= clamp_val[14:0];
        end else begin
          axis_out[tgt_t[AX_W-1:0]] <= signed'(clamp_val);
        end
      end else if (out_load_last) begin
        pend_valid <= 1'b0;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == OP_AXIS) begin
        cur_slot     <= ADDR_W'({in_index, 1'b0});
        new_level    <= neg_lvl;
        second_level <= pos_lvl;
      end else begin
        cur_slot  <= ADDR_W'(btn_slot_full);
        new_level <= pos_lvl;
      end
    end else if (go_next && second_pend) begin
      cur_slot  <= cur_slot + ADDR_W'(1);
      new_level <= second_level;
    end

    if (state == ST_CHECK) begin
      tgt_btn  <= map_rd[MAP_BUTTON_BIT];
      tgt_t    <= map_rd[5:0];
      acc      <= '0;
      walk_idx <= '0;
    end else begin
      if (state == ST_WALK) walk_idx <= walk_idx + CNT_W'(1);
      if (rd_vld) begin
        if (!rd_pos[0]) begin
          even_map <= map_rd;
          even_lvl <= lvl_rd;
        end else begin
          acc <= acc + ACC_W'(step_add);
        end
      end
    end
    rd_pos <= walk_idx[ADDR_W-1:0];

    if (state == ST_FINISH && out_free && value_changed) begin
      pend_btn   <= tgt_btn;
      pend_idx   <= tgt_t[3:0];
      pend_value <= clamp_val;
    end

    if (out_load) begin
      out_btn   <= pend_btn;
      out_idx   <= pend_idx;
      out_value <= pend_value;
      out_last  <= out_load_last;
    end
  end

  assign m_tdata = {4'd0, out_value, out_idx};
  assign m_tuser = out_btn;
  assign m_tlast = out_last;

endmodule
